>>> src/conv3_pkg.sv
package conv3_pkg;

    // kernel geometry, fixed
    localparam int KSIZE = 3;
    localparam int KTAPS = KSIZE * KSIZE;

    // fixed field widths
    localparam int WEIGHT_W   = 16;
    localparam int IDX_W      = 10;
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KSIZE * WEIGHT_W;

    localparam int MAX_HEIGHT = 1024;
    localparam int DIM_RESET  = 10;

    // defaults for the top-level parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_PIXEL_BITS = 16;

    // results a pixel can complete, in emission order
    localparam int RES_ABOVE_LEFT = 0;
    localparam int RES_ABOVE      = 1;
    localparam int RES_LEFT       = 2;
    localparam int RES_HERE       = 3;
    localparam int NUM_RES        = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_WEIGHTS_TOP    = 3'd2,
        REG_WEIGHTS_MIDDLE = 3'd3,
        REG_WEIGHTS_BOTTOM = 3'd4
    } conv3_reg_t;

    // position of one pixel and the edge flags derived from it
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             col_zero;
        logic             row_ge1;
        logic             row_ge2;
        logic             last_col;
        logic             last_row;
    } conv3_pos_t;

    // side information of one result beat
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             eof;
    } conv3_meta_t;

    // kernel row 0 in [0], column 0 in the low bits of each row
    typedef logic [KSIZE-1:0][CFG_DATA_W-1:0] conv3_weights_t;

endpackage

>>> src/conv3x3_zero_padded_stream.sv
// 3x3 zero-padded streaming correlation. Signed pixels enter in raster order, at most one
// beat per clock, and each output pixel leaves as the exact 36-bit (for 16-bit pixels)
// unflipped weighted sum of its 3x3 neighborhood, with zeros outside the image, tagged
// with its row and column, in raster order. A top-row pixel completes no result unless
// the image is one row tall, an inner pixel one, the last pixel of a row two, every
// bottom-row pixel after the first two, and the bottom-right pixel four. Results leave
// at one beat per cycle while m_ready holds, so the input takes one pixel per cycle
// when nothing stalls and pauses for every result of a pixel beyond its first: one at a
// row end, one at each bottom-row pixel, three at the frame end. That rate is set by the
// single shared multiply-add pipeline, which takes one window per cycle unless its output
// stalls. An input beat reaches its first result through the line buffer read, window
// update, operand register, products, row sums and output register. The two previous
// rows sit in one single-port-write RAM of MAX_WIDTH words of two pixels each, read
// in the cycle a pixel is taken and written back when that pixel moves on into the
// window; a read of the column just written is bypassed. The RAM is not cleared after
// reset and needs no clearing: rows are only used after this frame wrote them. Write
// image_width or image_height only while idle; either write starts a new frame. Weight
// writes apply to the next result computed.
module conv3x3_zero_padded_stream
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    // configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [CFG_DATA_W-1:0]                 cfg_wdata,

    // pixel input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [PIXEL_BITS-1:0]          s_pixel_in,

    // result output
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [PIXEL_BITS+WEIGHT_W+3:0] m_sum_out,
    output logic [IDX_W-1:0]                      m_out_row,
    output logic [IDX_W-1:0]                      m_out_col,
    output logic                                  m_last_in_run,
    output logic                                  m_end_of_frame
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 1;
    // width limit, capped by what the register field can hold
    localparam int WLIM  = (MAX_WIDTH > (1 << DIM_W) - 1) ? (1 << DIM_W) - 1 : MAX_WIDTH;

    // configuration registers
    logic [DIM_W-1:0] width_reg,   width_next;
    logic [DIM_W-1:0] height_reg,  height_next;
    conv3_weights_t   weights_reg, weights_next;
    logic             cfg_restart;

    // position of the next input pixel
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic             s_fire;
    logic             last_col;
    logic             last_row;
    conv3_pos_t       in_pos;

    // line buffer stage to window
    logic                         s1_valid;
    logic                         s1_take;
    logic signed [PIXEL_BITS-1:0] s1_pixel;
    logic signed [PIXEL_BITS-1:0] s1_up1;
    logic signed [PIXEL_BITS-1:0] s1_up2;
    conv3_pos_t                   s1_pos;

    // window to multiply-add pipeline
    logic                         iss_valid;
    logic                         iss_ready;
    logic signed [PIXEL_BITS-1:0] iss_x [KTAPS];
    conv3_meta_t                  iss_meta;
    conv3_meta_t                  out_meta;

    // clamp a written size into 1..lim
    function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) r = DIM_W'(1);
        if (v > lim) r = lim;
        return r;
    endfunction

    // configuration decode; writes past the register list are dropped
    always_comb begin
        width_next   = width_reg;
        height_next  = height_reg;
        weights_next = weights_reg;
        cfg_restart  = 1'b0;
        if (cfg_wr_en) begin
            case (conv3_reg_t'(cfg_index))
                REG_IMAGE_WIDTH: begin
                    width_next  = sat_dim(cfg_wdata[DIM_W-1:0], DIM_W'(WLIM));
                    cfg_restart = 1'b1;
                end
                REG_IMAGE_HEIGHT: begin
                    height_next = sat_dim(cfg_wdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
                    cfg_restart = 1'b1;
                end
                REG_WEIGHTS_TOP:    weights_next[0] = cfg_wdata;
                REG_WEIGHTS_MIDDLE: weights_next[1] = cfg_wdata;
                REG_WEIGHTS_BOTTOM: weights_next[2] = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= DIM_W'(DIM_RESET);
            height_reg  <= DIM_W'(DIM_RESET);
            weights_reg <= '0;
        end else begin
            width_reg   <= width_next;
            height_reg  <= height_next;
            weights_reg <= weights_next;
        end
    end

    // input beat acceptance and raster position
    assign s_ready = !s1_valid || s1_take;
    assign s_fire  = s_valid && s_ready;

    assign last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(width_reg);
    assign last_row = (DIM_W'(row_reg) + DIM_W'(1)) >= height_reg;

    always_comb begin
        in_pos.row      = row_reg;
        in_pos.col      = IDX_W'(col_reg);
        in_pos.col_zero = (col_reg == '0);
        in_pos.row_ge1  = (row_reg != '0);
        in_pos.row_ge2  = (row_reg >= ROW_W'(2));
        in_pos.last_col = last_col;
        in_pos.last_row = last_row;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_restart) begin
            col_next = '0;
            row_next = '0;
        end else if (s_fire) begin
            if (last_col) begin
                col_next = '0;
                // wrap to a new frame after the bottom row
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // two previous rows, addressed by column
    conv3_linebuf #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_linebuf (
        .clk      (aclk),
        .rstn     (aresetn),
        .in_fire  (s_fire),
        .in_pixel (s_pixel_in),
        .in_addr  (col_reg),
        .in_pos   (in_pos),
        .take     (s1_take),
        .s1_valid (s1_valid),
        .s1_pixel (s1_pixel),
        .s1_up1   (s1_up1),
        .s1_up2   (s1_up2),
        .s1_pos   (s1_pos)
    );

    // 3x3 window and the results each pixel completes
    conv3_window #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk       (aclk),
        .rstn      (aresetn),
        .restart   (cfg_restart),
        .s1_valid  (s1_valid),
        .s1_pixel  (s1_pixel),
        .s1_up1    (s1_up1),
        .s1_up2    (s1_up2),
        .s1_pos    (s1_pos),
        .s1_take   (s1_take),
        .iss_valid (iss_valid),
        .iss_ready (iss_ready),
        .iss_x     (iss_x),
        .iss_meta  (iss_meta)
    );

    // nine products and an adder tree, one window per cycle unless the output stalls
    conv3_mac #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (iss_valid),
        .in_ready  (iss_ready),
        .in_x      (iss_x),
        .in_meta   (iss_meta),
        .weights   (weights_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_sum   (m_sum_out),
        .out_meta  (out_meta)
    );

    assign m_out_row      = out_meta.row;
    assign m_out_col      = out_meta.col;
    assign m_last_in_run  = out_meta.last;
    assign m_end_of_frame = out_meta.eof;

`ifndef SYNTHESIS
    // the bottom-right pixel wraps the raster position to the frame origin
    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && last_col && last_row |=> (col_reg == '0) && (row_reg == '0))
        else $error("raster position did not wrap at frame end");

    // column counter stays inside the configured width
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(col_reg) < CMP_W'(width_reg))
        else $error("column counter beyond image width");

    // end-of-frame beat is the bottom-right pixel and closes its run
    a_eof_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |->
            m_last_in_run &&
            (m_out_row == IDX_W'(height_reg - DIM_W'(1))) &&
            (m_out_col == IDX_W'(width_reg - DIM_W'(1))))
        else $error("end-of-frame beat at wrong position");
`endif

endmodule

>>> src/conv3_linebuf.sv
module conv3_linebuf
    import conv3_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rstn,
    input  logic                                 in_fire,
    input  logic signed [PIXEL_BITS-1:0]         in_pixel,
    input  logic        [$clog2(MAX_WIDTH)-1:0]  in_addr,
    input  conv3_pos_t                           in_pos,
    input  logic                                 take,
    output logic                                 s1_valid,
    output logic signed [PIXEL_BITS-1:0]         s1_pixel,
    output logic signed [PIXEL_BITS-1:0]         s1_up1,
    output logic signed [PIXEL_BITS-1:0]         s1_up2,
    output conv3_pos_t                           s1_pos
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    // low half: row above, high half: two rows above
    logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

    logic                    valid_reg;
    logic [2*PIXEL_BITS-1:0] rdata_reg;
    logic [PIXEL_BITS-1:0]   pixel_reg;
    logic [ADDR_W-1:0]       addr_reg;
    conv3_pos_t              pos_reg;
    logic [2*PIXEL_BITS-1:0] wdata;

    assign s1_up1   = pos_reg.row_ge1 ? signed'(rdata_reg[PIXEL_BITS-1:0]) : '0;
    assign s1_up2   = pos_reg.row_ge2 ? signed'(rdata_reg[2*PIXEL_BITS-1:PIXEL_BITS]) : '0;
    assign s1_pixel = signed'(pixel_reg);
    assign s1_pos   = pos_reg;
    assign s1_valid = valid_reg;
    assign wdata    = {s1_up1, pixel_reg};

    // write-back of the shifted column; same-address read sees the new data
    always_ff @(posedge clk) begin
        if (take) begin
            line_mem[addr_reg] <= wdata;
        end
        if (in_fire) begin
            if (take && (addr_reg == in_addr)) begin
                rdata_reg <= wdata;
            end else begin
                rdata_reg <= line_mem[in_addr];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            pixel_reg <= in_pixel;
            addr_reg  <= in_addr;
            pos_reg   <= in_pos;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg <= 1'b0;
        end else if (in_fire) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

endmodule

>>> src/conv3_window.sv
module conv3_window
    import conv3_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                         clk,
    input  logic                         rstn,
    input  logic                         restart,
    input  logic                         s1_valid,
    input  logic signed [PIXEL_BITS-1:0] s1_pixel,
    input  logic signed [PIXEL_BITS-1:0] s1_up1,
    input  logic signed [PIXEL_BITS-1:0] s1_up2,
    input  conv3_pos_t                   s1_pos,
    output logic                         s1_take,
    output logic                         iss_valid,
    input  logic                         iss_ready,
    output logic signed [PIXEL_BITS-1:0] iss_x [KTAPS],
    output conv3_meta_t                  iss_meta
);

    // rows oldest first, columns oldest first
    logic signed [PIXEL_BITS-1:0] win_reg [KSIZE][KSIZE];
    logic [NUM_RES-1:0]           mask_reg;
    conv3_pos_t                   pos_reg;

    logic [NUM_RES-1:0] lowbit;
    logic [NUM_RES-1:0] rest;
    logic [NUM_RES-1:0] new_mask;
    logic               iss_fire;
    logic               dr;
    logic               dc;

    always_comb begin
        lowbit    = mask_reg & (~mask_reg + NUM_RES'(1));
        rest      = mask_reg & ~lowbit;
        iss_valid = |mask_reg;
        iss_fire  = iss_valid && iss_ready;
        s1_take   = s1_valid && ((mask_reg == '0) || (iss_ready && (rest == '0)));

        new_mask[RES_ABOVE_LEFT] = s1_pos.row_ge1 && !s1_pos.col_zero;
        new_mask[RES_ABOVE]      = s1_pos.row_ge1 && s1_pos.last_col;
        new_mask[RES_LEFT]       = s1_pos.last_row && !s1_pos.col_zero;
        new_mask[RES_HERE]       = s1_pos.last_row && s1_pos.last_col;

        dr = lowbit[RES_LEFT] | lowbit[RES_HERE];
        dc = lowbit[RES_ABOVE] | lowbit[RES_HERE];
    end

    // operand selection: window shifted by (dr,dc), padding past the edge
    always_comb begin
        for (int ki = 0; ki < KSIZE; ki++) begin
            for (int kj = 0; kj < KSIZE; kj++) begin
                case ({dr, dc})
                    2'b00: iss_x[ki*KSIZE+kj] = win_reg[ki][kj];
                    2'b01: iss_x[ki*KSIZE+kj] = (kj < KSIZE-1) ?
                        win_reg[ki][(kj < KSIZE-1) ? kj+1 : kj] : '0;
                    2'b10: iss_x[ki*KSIZE+kj] = (ki < KSIZE-1) ?
                        win_reg[(ki < KSIZE-1) ? ki+1 : ki][kj] : '0;
                    2'b11: iss_x[ki*KSIZE+kj] = (ki < KSIZE-1 && kj < KSIZE-1) ?
                        win_reg[(ki < KSIZE-1) ? ki+1 : ki][(kj < KSIZE-1) ? kj+1 : kj]
                        : '0;
                    default: iss_x[ki*KSIZE+kj] = '0;
                endcase
            end
        end
    end

    always_comb begin
        iss_meta.row  = (lowbit[RES_ABOVE_LEFT] | lowbit[RES_ABOVE]) ?
                        pos_reg.row - ROW_W'(1) : pos_reg.row;
        iss_meta.col  = (lowbit[RES_ABOVE_LEFT] | lowbit[RES_LEFT]) ?
                        pos_reg.col - IDX_W'(1) : pos_reg.col;
        iss_meta.last = (rest == '0);
        iss_meta.eof  = lowbit[RES_HERE];
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            mask_reg <= '0;
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (restart) begin
            for (int i = 0; i < KSIZE; i++) begin
                for (int j = 0; j < KSIZE; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else if (s1_take) begin
            mask_reg <= new_mask;
            for (int i = 0; i < KSIZE; i++) begin
                win_reg[i][0] <= s1_pos.col_zero ? '0 : win_reg[i][1];
                win_reg[i][1] <= s1_pos.col_zero ? '0 : win_reg[i][2];
            end
            win_reg[0][2] <= s1_up2;
            win_reg[1][2] <= s1_up1;
            win_reg[2][2] <= s1_pixel;
        end else if (iss_fire) begin
            mask_reg <= rest;
        end
    end

    always_ff @(posedge clk) begin
        if (s1_take) begin
            pos_reg <= s1_pos;
        end
    end

endmodule

>>> src/conv3_mac.sv
module conv3_mac
    import conv3_pkg::*;
#(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                                    clk,
    input  logic                                    rstn,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [PIXEL_BITS-1:0]            in_x [KTAPS],
    input  conv3_meta_t                             in_meta,
    input  conv3_weights_t                          weights,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [PIXEL_BITS+WEIGHT_W+3:0]   out_sum,
    output conv3_meta_t                             out_meta
);

    localparam int PROD_W = PIXEL_BITS + WEIGHT_W;
    localparam int PART_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;

    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic ra, rb, rc, rd;

    logic signed [PIXEL_BITS-1:0] x_a_reg    [KTAPS];
    logic signed [PROD_W-1:0]     prod_b_reg [KTAPS];
    logic signed [PART_W-1:0]     part_c_reg [KSIZE];
    logic signed [SUM_W-1:0]      sum_d_reg;
    conv3_meta_t                  meta_a_reg, meta_b_reg, meta_c_reg, meta_d_reg;

    logic signed [WEIGHT_W-1:0]   w [KTAPS];

    assign rd       = !vd_reg || out_ready;
    assign rc       = !vc_reg || rd;
    assign rb       = !vb_reg || rc;
    assign ra       = !va_reg || rb;
    assign in_ready = ra;

    assign out_valid = vd_reg;
    assign out_sum   = sum_d_reg;
    assign out_meta  = meta_d_reg;

    always_comb begin
        for (int ki = 0; ki < KSIZE; ki++) begin
            for (int kj = 0; kj < KSIZE; kj++) begin
                w[ki*KSIZE+kj] = signed'(weights[ki][WEIGHT_W*kj +: WEIGHT_W]);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (ra) va_reg <= in_valid;
            if (rb) vb_reg <= va_reg;
            if (rc) vc_reg <= vb_reg;
            if (rd) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (ra) begin
            x_a_reg    <= in_x;
            meta_a_reg <= in_meta;
        end
        if (rb) begin
            for (int k = 0; k < KTAPS; k++) begin
                prod_b_reg[k] <= PROD_W'(x_a_reg[k]) * PROD_W'(w[k]);
            end
            meta_b_reg <= meta_a_reg;
        end
        if (rc) begin
            for (int ki = 0; ki < KSIZE; ki++) begin
                part_c_reg[ki] <= PART_W'(prod_b_reg[ki*KSIZE])
                                + PART_W'(prod_b_reg[ki*KSIZE+1])
                                + PART_W'(prod_b_reg[ki*KSIZE+2]);
            end
            meta_c_reg <= meta_b_reg;
        end
        if (rd) begin
            sum_d_reg  <= SUM_W'(part_c_reg[0]) + SUM_W'(part_c_reg[1])
                        + SUM_W'(part_c_reg[2]);
            meta_d_reg <= meta_c_reg;
        end
    end

endmodule
